@@ hw/rtl/fdfp_pkg.sv @@
`default_nettype none

package fdfp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned TOKEN_W     = 4;
  localparam int unsigned OUT_SLOTS   = 8;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 136;

  // Bit positions inside the result word.
  localparam int unsigned OUT_LEN_BIT   = 128;
  localparam int unsigned OUT_FOUND_LSB = 129;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_RST    = 8'h2C;
  localparam logic [BYTE_W-1:0] END_RST       = 8'h60;
  localparam logic [BYTE_W-1:0] SEPARATOR_RST = 8'h2D;

  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_POS  = 2'd1,
    PH_NEG  = 2'd2,
    PH_STOP = 2'd3
  } number_phase_e;

  typedef struct packed {
    number_phase_e        phase;
    logic [VALUE_W-1:0]   value;
  } conv_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/fdfp_num_conv.sv @@
`default_nettype none

module fdfp_num_conv (
  input  fdfp_pkg::conv_state_t           st_i,
  input  logic [fdfp_pkg::BYTE_W-1:0]     byte_i,
  output fdfp_pkg::conv_state_t           st_o
);

  logic                           is_digit;
  logic                           is_space;
  logic [fdfp_pkg::VALUE_W-1:0]   digit_val;
  logic [fdfp_pkg::VALUE_W-1:0]   times_ten;

  assign is_digit  = (byte_i >= fdfp_pkg::CHAR_ZERO) && (byte_i <= fdfp_pkg::CHAR_NINE);
  assign is_space  = (byte_i == fdfp_pkg::CHAR_SPACE) ||
                     ((byte_i >= fdfp_pkg::CHAR_TAB) && (byte_i <= fdfp_pkg::CHAR_CR));
  assign digit_val = {{(fdfp_pkg::VALUE_W-4){1'b0}}, byte_i[3:0]};
  assign times_ten = (st_i.value << 3) + (st_i.value << 1);

  always_comb begin
    st_o = st_i;
    case (st_i.phase)
      fdfp_pkg::PH_SKIP: begin
        if (is_space) begin
          st_o.phase = fdfp_pkg::PH_SKIP;
        end else if (byte_i == fdfp_pkg::CHAR_PLUS) begin
          st_o.phase = fdfp_pkg::PH_POS;
        end else if (byte_i == fdfp_pkg::CHAR_MINUS) begin
          st_o.phase = fdfp_pkg::PH_NEG;
        end else if (is_digit) begin
          st_o.phase = fdfp_pkg::PH_POS;
          st_o.value = digit_val;
        end else begin
          st_o.phase = fdfp_pkg::PH_STOP;
        end
      end
      fdfp_pkg::PH_POS: begin
        if (is_digit) begin
          st_o.value = times_ten + digit_val;
        end else begin
          st_o.phase = fdfp_pkg::PH_STOP;
        end
      end
      fdfp_pkg::PH_NEG: begin
        if (is_digit) begin
          st_o.value = times_ten - digit_val;
        end else begin
          st_o.phase = fdfp_pkg::PH_STOP;
        end
      end
      default: begin
        st_o.phase = fdfp_pkg::PH_STOP;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/framed_decimal_field_parser.sv @@
// A word accepted at the input is held in an input register and parsed from there; a packet's result
// word is registered onto the output from the parse of its closing byte.
// Throughput: one input byte per cycle, held back only while a result word stalls.
// Reset clears the packet state, the stored values and both valid flags, and loads
// the header, end and separator registers with 0x2C, 0x60 and 0x2D.
`default_nettype none

module framed_decimal_field_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 52,
  parameter int unsigned NUM_FIELDS       = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fdfp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fdfp_pkg::BYTE_W-1:0]          cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // rx_byte
  input  logic [fdfp_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // value_0 .. value_7, ended_by_length, fields_found, zero padding
  output logic [fdfp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned SLOT_W = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;

  logic [fdfp_pkg::BYTE_W-1:0]    hdr_q, end_q, sep_q;

  logic                           in_vld_q;
  logic [fdfp_pkg::BYTE_W-1:0]    in_byte_q;
  logic                           advance;

  logic [fdfp_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
  logic [fdfp_pkg::COUNT_W:0]     cnt_nxt;
  logic [fdfp_pkg::TOKEN_W-1:0]   tok_q, tok_d, tok_new;
  logic                           inside_q, inside_d;
  logic                           ended_q, ended_d;
  fdfp_pkg::number_phase_e        phase_q, phase_d, phase_eff;
  logic [fdfp_pkg::VALUE_W-1:0]   vals_q [NUM_FIELDS];
  logic [fdfp_pkg::VALUE_W-1:0]   vals_d [NUM_FIELDS];

  logic                           bump;
  logic [SLOT_W-1:0]              slot;
  fdfp_pkg::conv_state_t          conv_in, conv_out;

  logic                           emit, emit_len;

  logic                           out_vld_q;
  logic [fdfp_pkg::VALUE_W-1:0]   out_val_q [NUM_FIELDS];
  logic                           out_len_q;
  logic [fdfp_pkg::TOKEN_W-1:0]   out_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= fdfp_pkg::HEADER_RST;
      end_q <= fdfp_pkg::END_RST;
      sep_q <= fdfp_pkg::SEPARATOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdfp_pkg::REG_HEADER:    hdr_q <= cfg_wdata_i;
        fdfp_pkg::REG_END:       end_q <= cfg_wdata_i;
        fdfp_pkg::REG_SEPARATOR: sep_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  assign cnt_nxt   = {1'b0, cnt_q} + 7'd1;
  assign bump      = !inside_q && (tok_q < fdfp_pkg::TOKEN_W'(NUM_FIELDS));
  assign tok_new   = bump ? tok_q + 4'd1 : tok_q;
  assign phase_eff = bump ? fdfp_pkg::PH_SKIP : (!inside_q ? fdfp_pkg::PH_STOP : phase_q);
  assign slot      = SLOT_W'(tok_new - 4'd1);

  assign conv_in.phase = phase_eff;
  assign conv_in.value = vals_q[slot];

  fdfp_num_conv u_conv (
    .st_i   (conv_in),
    .byte_i (in_byte_q),
    .st_o   (conv_out)
  );

  always_comb begin
    cnt_d    = cnt_q;
    tok_d    = tok_q;
    inside_d = inside_q;
    ended_d  = ended_q;
    phase_d  = phase_q;
    vals_d   = vals_q;
    emit     = 1'b0;
    emit_len = 1'b0;
    if (advance) begin
      if (cnt_q == '0) begin
        if (in_byte_q == hdr_q) begin
          if (in_byte_q == end_q) begin
            emit = 1'b1;
          end else begin
            cnt_d = 6'd1;
          end
        end
      end else if ((cnt_nxt >= 7'(MAX_PACKET_BYTES)) || (in_byte_q == end_q)) begin
        emit     = 1'b1;
        emit_len = (in_byte_q != end_q);
        cnt_d    = '0;
        tok_d    = '0;
        inside_d = 1'b0;
        ended_d  = 1'b0;
        phase_d  = fdfp_pkg::PH_SKIP;
        vals_d   = '{default: '0};
      end else begin
        cnt_d = cnt_nxt[fdfp_pkg::COUNT_W-1:0];
        if (!ended_q) begin
          if (in_byte_q == fdfp_pkg::CHAR_NUL) begin
            ended_d = 1'b1;
          end else if (in_byte_q == sep_q) begin
            inside_d = 1'b0;
          end else begin
            inside_d = 1'b1;
            tok_d    = tok_new;
            if ((phase_eff != fdfp_pkg::PH_STOP) && (tok_new != '0)) begin
              phase_d      = conv_out.phase;
              vals_d[slot] = conv_out.value;
            end else begin
              phase_d = phase_eff;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      tok_q    <= '0;
      inside_q <= 1'b0;
      ended_q  <= 1'b0;
      phase_q  <= fdfp_pkg::PH_SKIP;
      vals_q   <= '{default: '0};
    end else begin
      cnt_q    <= cnt_d;
      tok_q    <= tok_d;
      inside_q <= inside_d;
      ended_q  <= ended_d;
      phase_q  <= phase_d;
      vals_q   <= vals_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_val_q   <= vals_q;
      out_len_q   <= emit_len;
      out_found_q <= tok_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;

  for (genvar k = 0; k < fdfp_pkg::OUT_SLOTS; k++) begin : g_out
    if (k < NUM_FIELDS) begin : g_used
      assign m_axis_tdata_o[k*fdfp_pkg::VALUE_W +: fdfp_pkg::VALUE_W] = out_val_q[k];
    end else begin : g_unused
      assign m_axis_tdata_o[k*fdfp_pkg::VALUE_W +: fdfp_pkg::VALUE_W] = '0;
    end
  end

  assign m_axis_tdata_o[fdfp_pkg::OUT_LEN_BIT] = out_len_q;
  assign m_axis_tdata_o[fdfp_pkg::OUT_FOUND_LSB +: fdfp_pkg::TOKEN_W] = out_found_q;
  assign m_axis_tdata_o[fdfp_pkg::OUT_TDATA_W-1:fdfp_pkg::OUT_FOUND_LSB+fdfp_pkg::TOKEN_W] =
    '0;

endmodule

`default_nettype wire

@@ hw/rtl/fdfp_checker.sv @@
`default_nettype none

module fdfp_checker (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  input  wire [fdfp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  logic [fdfp_pkg::TOKEN_W-1:0] found;

  assign found = m_axis_tdata_o[fdfp_pkg::OUT_FOUND_LSB +: fdfp_pkg::TOKEN_W];

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  a_found_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> found <= fdfp_pkg::TOKEN_W'(fdfp_pkg::OUT_SLOTS))
    else $error("field count above eight");

  // With no token seen, every value must still be zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (found == '0) |-> m_axis_tdata_o[127:0] == '0)
    else $error("nonzero value without any token");

  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[127:112] != '0) |->
      found == fdfp_pkg::TOKEN_W'(fdfp_pkg::OUT_SLOTS))
    else $error("eighth value set with fewer than eight tokens");

endmodule

bind framed_decimal_field_parser fdfp_checker u_fdfp_checker (.*);

`default_nettype wire
